// ===== design/fpd_pkg.sv =====
`default_nettype none

package fpd_pkg;

  // Scale register, unsigned Q8.24.
  localparam int unsigned COEF_W = 32;
  localparam logic [COEF_W-1:0] COEF_RESET = 32'h0100_0000;

  // Result word, signed Q40.8, taken from the product above this shift.
  localparam int unsigned DERIV_W     = 48;
  localparam int unsigned DERIV_SHIFT = 16;
  localparam int unsigned WRAP_W      = 64;

  // Saturating position counter within a record.
  localparam int unsigned COUNT_W = 3;
  localparam logic [COUNT_W-1:0] COUNT_ZERO = 3'd0;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = 3'd1;
  localparam logic [COUNT_W-1:0] POS_OPEN   = 3'd3;
  localparam logic [COUNT_W-1:0] POS_FULL   = 3'd5;

  // Configuration map: register index as decoded from the APB address.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned REG_IDX_LSB = 2;
  localparam logic [0:0] REG_INVERSE_TWELVE_STEP = 1'b0;
  localparam int unsigned PDATA_W = 32;

  // Job queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef struct packed {
    logic full;
    logic empty;
  } fpd_q_status_t;

endpackage

`default_nettype wire

// ===== design/fpd_if.sv =====
`default_nettype none

interface fpd_sample_if #(
  parameter int unsigned SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           end_of_record;

  modport source (output valid, output sample, output end_of_record, input ready);
  modport sink   (input valid, input sample, input end_of_record, output ready);
endinterface

interface fpd_deriv_if;
  logic                                valid;
  logic                                ready;
  logic signed [fpd_pkg::DERIV_W-1:0]  derivative;
  logic                                last_result;

  modport source (output valid, output derivative, output last_result, input ready);
  modport sink   (input valid, input derivative, input last_result, output ready);
endinterface

`default_nettype wire

// ===== design/fpd_front.sv =====
`default_nettype none

module fpd_front #(
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned DIFF_W       = SAMPLE_WIDTH + 5,
  parameter int unsigned JOB_W        = 2 * DIFF_W + 2
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  fpd_sample_if.sink                  sample_i,
  input  wire fpd_pkg::fpd_q_status_t q_status_i,
  output logic                        push_o,
  output logic [JOB_W-1:0]            job_o
);
  import fpd_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] win_q [4];
  logic [COUNT_W-1:0]             seen_q, seen_d;
  logic [COUNT_W-1:0]             pos;
  logic                           accept;
  logic signed [SAMPLE_WIDTH:0]   diff_a, diff_b, diff_c;
  logic signed [DIFF_W-1:0]       ext_a, ext_b, ext_c;
  logic signed [DIFF_W-1:0]       six_d, five_d, int_d;
  logic                           int_v, cls_v;

  assign sample_i.ready = !q_status_i.full;
  assign accept = sample_i.valid && sample_i.ready;

  assign pos = (seen_q == POS_FULL) ? POS_FULL : seen_q + COUNT_ONE;

  // Opening and closing difference x[k]-x[k-2], interior stencil terms.
  assign diff_a = sample_i.sample - win_q[1];
  assign diff_b = win_q[0] - win_q[2];
  assign diff_c = sample_i.sample - win_q[3];
  assign ext_a  = DIFF_W'(diff_a);
  assign ext_b  = DIFF_W'(diff_b);
  assign ext_c  = DIFF_W'(diff_c);
  assign six_d  = (ext_a <<< 2) + (ext_a <<< 1);
  assign five_d = (ext_b <<< 3) - ext_c;

  always_comb begin
    int_v = 1'b0;
    int_d = five_d;
    if (pos == POS_OPEN && !sample_i.end_of_record) begin
      int_v = 1'b1;
      int_d = six_d;
    end else if (pos == POS_FULL) begin
      int_v = 1'b1;
    end
  end

  assign cls_v  = sample_i.end_of_record && (pos >= POS_OPEN);
  assign push_o = accept && (int_v || cls_v);
  assign job_o  = {int_v, cls_v, int_d, six_d};

  assign seen_d = sample_i.end_of_record ? COUNT_ZERO : pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= COUNT_ZERO;
    end else if (accept) begin
      seen_q <= seen_d;
    end
  end

  // The window is only read at positions already filled in this record.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q[0] <= sample_i.sample;
      win_q[1] <= win_q[0];
      win_q[2] <= win_q[1];
      win_q[3] <= win_q[2];
    end
  end

endmodule

`default_nettype wire

// ===== design/fpd_queue.sv =====
`default_nettype none

module fpd_queue #(
  parameter int unsigned JOB_W = 60
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire logic [JOB_W-1:0]        push_data_i,
  input  wire logic                    pop_i,
  output logic [JOB_W-1:0]             head_o,
  output fpd_pkg::fpd_q_status_t       status_o
);
  import fpd_pkg::*;

  logic [JOB_W-1:0]  mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/fpd_back.sv =====
`default_nettype none

module fpd_back #(
  parameter int unsigned DIFF_W = 29,
  parameter int unsigned JOB_W  = 2 * DIFF_W + 2
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [fpd_pkg::COEF_W-1:0]   coef_i,
  input  wire logic [JOB_W-1:0]             head_i,
  input  wire fpd_pkg::fpd_q_status_t       q_status_i,
  output logic                              pop_o,
  fpd_deriv_if.source                       deriv_o
);
  import fpd_pkg::*;

  localparam int unsigned PROD_W = DIFF_W + COEF_W + 1;
  localparam int unsigned EXT_W  = (PROD_W > WRAP_W) ? PROD_W : WRAP_W;

  logic                     head_int_v, head_cls_v;
  logic signed [DIFF_W-1:0] head_int_d, head_cls_d, d_sel;
  logic                     part_q, part_d;
  logic                     issue, issue_int, last_sel;
  logic signed [PROD_W-1:0] prod;
  logic signed [EXT_W-1:0]  prod_ext;
  logic                     out_v_q;
  logic signed [DERIV_W-1:0] deriv_q;
  logic                     last_q;

  assign head_int_v = head_i[JOB_W-1];
  assign head_cls_v = head_i[JOB_W-2];
  assign head_int_d = head_i[2*DIFF_W-1:DIFF_W];
  assign head_cls_d = head_i[DIFF_W-1:0];

  // A job carries an interior result, a closing result, or both in that order.
  assign issue_int = head_int_v && !part_q;
  assign d_sel     = issue_int ? head_int_d : head_cls_d;
  assign last_sel  = !issue_int;
  assign issue     = !q_status_i.empty && (!out_v_q || deriv_o.ready);
  assign pop_o     = issue && !(issue_int && head_cls_v);
  assign part_d    = issue ? (issue_int && head_cls_v) : part_q;

  assign prod     = $signed(PROD_W'(d_sel)) * $signed(PROD_W'({1'b0, coef_i}));
  assign prod_ext = EXT_W'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      part_q <= part_d;
      if (issue) begin
        out_v_q <= 1'b1;
      end else if (deriv_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      deriv_q <= prod_ext[DERIV_SHIFT +: DERIV_W];
      last_q  <= last_sel;
    end
  end

  assign deriv_o.valid       = out_v_q;
  assign deriv_o.derivative  = deriv_q;
  assign deriv_o.last_result = last_q;

endmodule

`default_nettype wire

// ===== design/five_point_derivative_stream_top.sv =====
// Five-point first derivative over a stream of signed samples.
// Samples enter as beats on sample_i (valid/ready); the end_of_record bit
// flags the final sample of a record. Derivative beats leave on deriv_o,
// each a signed Q40.8 value, with last_result set on the record's final one.
// The third sample, unless it ends the record, gives the opening three-point
// difference, each sample from the fifth on gives the stencil value for the
// position two back, and the final sample adds the closing three-point
// difference. Records of fewer than three samples produce nothing.
// A result passes through the job queue and the output register before it
// is valid on deriv_o. Throughput: one sample per cycle while the queue is
// not full; the back end retires one derivative per cycle while deriv_o is
// ready, set by its single multiplier and output register. A four-entry job
// queue between front and back absorbs a final sample's two derivatives.
// When deriv_o stalls, the output register holds its beat, the queue fills,
// and sample_i.ready drops only once the queue is full.
// Reset clears the record position, the queue and the output valid, and sets
// the scale register to 1.0. The scale is written over APB at address 0.
`default_nettype none

module five_point_derivative_stream_top #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // APB configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fpd_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [fpd_pkg::PDATA_W-1:0]   pwdata,
  output logic [fpd_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready,
  // Streams.
  fpd_sample_if.sink                         sample_i,
  fpd_deriv_if.source                        deriv_o
);
  import fpd_pkg::*;

  // Difference width: 8*(a-b)-(c-d) needs the sample width plus five bits.
  localparam int unsigned DIFF_W = SAMPLE_WIDTH + 5;
  localparam int unsigned JOB_W  = 2 * DIFF_W + 2;

  logic [COEF_W-1:0] coef_q;
  logic              reg_hit;
  logic              push;
  logic              pop;
  logic [JOB_W-1:0]  job;
  logic [JOB_W-1:0]  head;
  fpd_q_status_t     q_status;

  // Register decode: the index is the address in words.
  assign reg_hit = (paddr[REG_IDX_LSB] == REG_INVERSE_TWELVE_STEP);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? PDATA_W'(coef_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEF_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      coef_q <= COEF_W'(pwdata);
    end
  end

  // Front: sample window, record position and the weighted differences.
  fpd_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .DIFF_W       (DIFF_W),
    .JOB_W        (JOB_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (job)
  );

  // Jobs wait here so the two sides stall independently.
  fpd_queue #(
    .JOB_W (JOB_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  // Back: splits jobs into results, scales and registers them.
  fpd_back #(
    .DIFF_W (DIFF_W),
    .JOB_W  (JOB_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .coef_i     (coef_q),
    .head_i     (head),
    .q_status_i (q_status),
    .pop_o      (pop),
    .deriv_o    (deriv_o)
  );

endmodule

`default_nettype wire

// ===== test/tb_five_point_derivative_stream_top.sv =====
module tb_five_point_derivative_stream_top;
  import fpd_pkg::*;

  // Sample width used for this run, and the extremes of a sample at that width.
  localparam int unsigned SW = 24;
  localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

  // Random stimulus is split into phases, each run at its own scale setting.
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BEATS   = 322;

  // Results trail a sample beat through queue and output; these pauses cover that.
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 10;

  // How a directed row gets its expected beats: from the predictor, or typed in.
  localparam int PREDICTED  = -1;
  localparam int NO_RESULT  = 0;
  localparam int ONE_RESULT = 1;

  // Register index past the end of the map; writes to it must be dropped.
  localparam logic [0:0] REG_UNMAPPED = 1'b1;

  typedef struct packed {
    logic signed [DERIV_W-1:0] derivative;
    logic                      last_result;
  } deriv_beat_t;

  typedef struct packed {
    logic signed [SW-1:0]      smp;
    logic                      eor;
    int                        typed;
    logic signed [DERIV_W-1:0] val;
    logic                      lst;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  fpd_sample_if #(.SAMPLE_WIDTH(SW)) smp_if ();
  fpd_deriv_if                       drv_if ();

  five_point_derivative_stream_top #(.SAMPLE_WIDTH(SW)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .sample_i (smp_if),
    .deriv_o  (drv_if)
  );

  // Our own copy of the block's state: the last four samples (newest first),
  // the saturating position within the record, and the scale register.
  logic signed [SW-1:0] window_q [4];
  logic [COUNT_W-1:0]   seen_q;
  logic [COEF_W-1:0]    inv_step_q;

  // Derivative beats still owed by the block, oldest first, and the beats
  // that the most recent sample produced.
  deriv_beat_t pending_derivs [$];
  deriv_beat_t step_results [$];

  stim_row_t dir_rows [$];
  int        n_err;
  bit        idle_on;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; far above the slowest correct run.
  initial begin
    #2000000;
    $display("tb_five_point_derivative_stream_top: done, errors");
    $finish;
  end

  // Gap lengths: mostly none, often short, now and then a long one.
  function automatic int pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Half the samples are fully random words, so every bit sees both values.
  // The rest are rail values or small numbers near zero.
  function automatic logic signed [SW-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return SW'($urandom());
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0: return SMP_MAX;
        1: return SMP_MIN;
        2: return '0;
        default: return '1;
      endcase
    end
    return SW'($urandom_range(0, 2000) - 1000);
  endfunction

  // Record lengths: short records that emit nothing, the three- and four-sample
  // special cases, the common mid-length records, and long ones.
  function automatic int pick_record_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(1, 2);
    if (r < 25) return $urandom_range(3, 4);
    if (r < 85) return $urandom_range(5, 16);
    return $urandom_range(17, 60);
  endfunction

  function automatic logic [PADDR_W-1:0] reg_addr(input logic [0:0] idx);
    return PADDR_W'(idx) << REG_IDX_LSB;
  endfunction

  // The weighted difference times the Q8.24 scale, kept in 64 wrapping bits;
  // bits 16 and up form the Q40.8 result, so the shift floors toward minus
  // infinity and anything past 48 bits wraps.
  function automatic deriv_beat_t make_beat(input longint d, input logic last);
    logic [WRAP_W-1:0] prod;
    deriv_beat_t       b;
    prod = d * longint'({32'd0, inv_step_q});
    b.derivative  = prod[DERIV_SHIFT +: DERIV_W];
    b.last_result = last;
    return b;
  endfunction

  // Expected derivative beats for one accepted sample, in the order the block
  // sends them, followed by the window and position update.
  task automatic compute_derivatives(input logic signed [SW-1:0] s, input logic eor);
    logic [COUNT_W-1:0] pos;
    longint             cur;
    longint             w0;
    longint             w1;
    longint             w2;
    longint             w3;
    cur = s;
    w0  = window_q[0];
    w1  = window_q[1];
    w2  = window_q[2];
    w3  = window_q[3];
    step_results.delete();
    pos = (seen_q >= POS_FULL) ? POS_FULL : seen_q + COUNT_ONE;
    // Opening three-point difference, unless this third sample also ends the
    // record, in which case it is the closing one below.
    if (pos == POS_OPEN && !eor) step_results.push_back(make_beat(6 * (cur - w1), 1'b0));
    // Five-point stencil for the position two samples back.
    if (pos >= POS_FULL) begin
      step_results.push_back(make_beat(8 * (w0 - w2) - (cur - w3), 1'b0));
    end
    // Closing three-point difference comes after any interior beat.
    if (eor && pos >= POS_OPEN) step_results.push_back(make_beat(6 * (cur - w1), 1'b1));
    if (eor) begin
      foreach (window_q[i]) window_q[i] = '0;
      seen_q = COUNT_ZERO;
    end else begin
      window_q[3] = window_q[2];
      window_q[2] = window_q[1];
      window_q[1] = window_q[0];
      window_q[0] = s;
      seen_q      = pos;
    end
  endtask

  // Offers one sample beat after a random gap and waits until it is taken.
  // Valid stays high into the next beat when that beat has no gap.
  task automatic send_beat(input logic signed [SW-1:0] s, input logic eor,
                           input bit use_prediction);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid         <= 1'b1;
    smp_if.sample        <= s;
    smp_if.end_of_record <= eor;
    do @(posedge clk_i); while (!(smp_if.valid && smp_if.ready));
    compute_derivatives(s, eor);
    if (use_prediction) begin
      foreach (step_results[i]) pending_derivs.push_back(step_results[i]);
    end
  endtask

  task automatic apb_write(input logic [0:0] idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(idx);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [0:0] idx, input logic [PDATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(idx);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      $display("%0t: scale readback expected %h, got %h", $time, want, prdata);
      n_err++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // The scale is only touched while the block is quiet. Each setting is
  // followed by a write to the unmapped index, which the readback must not see.
  task automatic set_scale(input logic [COEF_W-1:0] value);
    apb_write(REG_INVERSE_TWELVE_STEP, value);
    inv_step_q = value;
    apb_write(REG_UNMAPPED, $urandom());
    apb_read_check(REG_INVERSE_TWELVE_STEP, inv_step_q);
  endtask

  // Stop offering samples, wait for every owed beat, then wait out the settle
  // pause in case the last sample was one that emits nothing.
  task automatic settle();
    smp_if.valid <= 1'b0;
    while (pending_derivs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_row(input logic signed [SW-1:0] s, input logic eor, input int typed,
                         input logic signed [DERIV_W-1:0] val, input logic lst);
    stim_row_t r;
    r.smp   = s;
    r.eor   = eor;
    r.typed = typed;
    r.val   = val;
    r.lst   = lst;
    dir_rows.push_back(r);
  endtask

  // Derivative sink: ready drops for random stretches, except while idling is
  // switched off, when every beat is taken at once.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        drv_if.ready <= 1'b0;
        stall--;
      end else begin
        drv_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) stall = pick_gap() + 1;
      end
    end
  end

  // Every derivative beat is checked against the oldest owed beat.
  always @(posedge clk_i) begin
    deriv_beat_t want;
    if (rst_ni && drv_if.valid && drv_if.ready) begin
      if (pending_derivs.size() == 0) begin
        $display("%0t: unexpected derivative beat, value %0d last %b", $time,
                 drv_if.derivative, drv_if.last_result);
        n_err++;
      end else begin
        want = pending_derivs.pop_front();
        if (drv_if.derivative !== want.derivative) begin
          $display("%0t: derivative expected %0d, got %0d", $time,
                   want.derivative, drv_if.derivative);
          n_err++;
        end
        if (drv_if.last_result !== want.last_result) begin
          $display("%0t: last_result expected %b, got %b", $time,
                   want.last_result, drv_if.last_result);
          n_err++;
        end
      end
    end
  end

  initial begin
    int                   len;
    int                   beats;
    logic signed [SW-1:0] s;
    logic [COEF_W-1:0]    scale_val;
    stim_row_t            row;
    deriv_beat_t          typed_beat;

    n_err                = 0;
    idle_on              = 1'b1;
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    smp_if.valid         = 1'b0;
    smp_if.sample        = '0;
    smp_if.end_of_record = 1'b0;
    drv_if.ready         = 1'b0;
    foreach (window_q[i]) window_q[i] = '0;
    seen_q     = COUNT_ZERO;
    inv_step_q = COEF_RESET;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The scale must come out of reset at 1.0.
    apb_read_check(REG_INVERSE_TWELVE_STEP, COEF_RESET);

    // Directed records at a scale of 1.0, where each typed value is just the
    // weighted difference times 256.
    // Three samples: one closing beat, 6*10.
    add_row(24'sd0,  1'b0, NO_RESULT,  '0, 1'b0);
    add_row(24'sd5,  1'b0, NO_RESULT,  '0, 1'b0);
    add_row(24'sd10, 1'b1, ONE_RESULT, 48'sd15360, 1'b1);
    // Records of one and of two samples produce nothing.
    add_row(24'sd7,  1'b1, NO_RESULT,  '0, 1'b0);
    add_row(24'sd7,  1'b0, NO_RESULT,  '0, 1'b0);
    add_row(24'sd9,  1'b1, NO_RESULT,  '0, 1'b0);
    // Four samples across the rails: opening beat on the third, closing on the
    // fourth.
    add_row(SMP_MIN, 1'b0, NO_RESULT,  '0, 1'b0);
    add_row(24'sd0,  1'b0, NO_RESULT,  '0, 1'b0);
    add_row(SMP_MAX, 1'b0, ONE_RESULT, 48'sd25769802240, 1'b0);
    add_row(SMP_MIN, 1'b1, ONE_RESULT, -48'sd12884901888, 1'b1);
    // Seven samples: the stencil at its largest swing, the position counter
    // saturating, and the last sample sending interior then closing beats.
    add_row(SMP_MAX, 1'b0, PREDICTED,  '0, 1'b0);
    add_row(SMP_MIN, 1'b0, PREDICTED,  '0, 1'b0);
    add_row(24'sd0,  1'b0, PREDICTED,  '0, 1'b0);
    add_row(SMP_MAX, 1'b0, PREDICTED,  '0, 1'b0);
    add_row(SMP_MIN, 1'b0, PREDICTED,  '0, 1'b0);
    add_row(-24'sd1, 1'b0, PREDICTED,  '0, 1'b0);
    add_row(24'sd1,  1'b1, PREDICTED,  '0, 1'b0);
    // Three samples ending on the top rail.
    add_row(-24'sd1, 1'b0, NO_RESULT,  '0, 1'b0);
    add_row(SMP_MIN, 1'b0, NO_RESULT,  '0, 1'b0);
    add_row(SMP_MAX, 1'b1, ONE_RESULT, 48'sd12884901888, 1'b1);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_beat(row.smp, row.eor, row.typed == PREDICTED);
      if (row.typed == ONE_RESULT) begin
        typed_beat.derivative  = row.val;
        typed_beat.last_result = row.lst;
        pending_derivs.push_back(typed_beat);
      end
    end
    settle();

    // Random records, one scale per phase, the register's extremes among them.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: scale_val = 32'hFFFF_FFFF;
        1: scale_val = 32'h0000_0000;
        2: scale_val = 32'h0000_0001;
        4: scale_val = 32'h0015_5555;
        default: scale_val = $urandom();
      endcase
      set_scale(scale_val);
      beats = 0;
      while (beats < PHASE_BEATS) begin
        // Now and then switch idling off for a stretch of back-to-back beats.
        if ($urandom_range(0, 7) == 0) idle_on = ($urandom_range(0, 3) != 0);
        len = pick_record_len();
        for (int k = 0; k < len; k++) begin
          s = pick_sample();
          send_beat(s, k == len - 1, 1'b1);
        end
        beats += len;
      end
      idle_on = 1'b1;
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_err == 0) begin
      $display("tb_five_point_derivative_stream_top: done, clean");
    end else begin
      $display("tb_five_point_derivative_stream_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/fpd_pkg.sv
design/fpd_if.sv
design/fpd_front.sv
design/fpd_queue.sv
design/fpd_back.sv
design/five_point_derivative_stream_top.sv
test/tb_five_point_derivative_stream_top.sv
